/* design/sws_pkg.sv */
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and constants for the stack with sink block.
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int Depth    = 64;                  // words of stack storage
  localparam int AddrW    = $clog2(Depth);
  localparam int CntW     = $clog2(Depth + 1);   // holds 0..Depth
  localparam int DataW    = 32;
  localparam int DistW    = 6;
  localparam int CapW     = 7;
  localparam int CntOutW  = 7;
  localparam int CmpW     = (CntW > CapW) ? CntW : CapW;

  localparam logic [CapW-1:0] CapReset = 7'd64;

  typedef enum logic [1:0] {
    FnPush   = 2'd0,
    FnPop    = 2'd1,
    FnSink   = 2'd2,
    FnStatus = 2'd3
  } func_e;

  typedef struct packed {
    func_e                    func;
    logic signed [DataW-1:0]  push_value;
    logic [DistW-1:0]         sink_distance;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DataW-1:0]  pop_value;
    logic [CntOutW-1:0]       count;
    logic                     is_empty;
  } rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StPopRd,
    StSkFirst,
    StSkShift,
    StSkLast,
    StResp
  } st_e;

endpackage

/* design/sws_ram.sv */
// ----------------------------------------------------------------------------
// sws_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sws_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/sws_ctrl.sv */
// ----------------------------------------------------------------------------
// sws_ctrl
// Request sequencer: decodes one request, drives the stack RAM, builds result.
// ----------------------------------------------------------------------------
module sws_ctrl import sws_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request side
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  req_t               in_req_i,
  // result side
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output rsp_t               rsp_o,
  // capacity register
  input  logic               cfg_we_i,
  input  logic [CapW-1:0]    cfg_wdata_i,
  // stack RAM
  output logic               ram_we_o,
  output logic [AddrW-1:0]   ram_waddr_o,
  output logic [DataW-1:0]   ram_wdata_o,
  output logic [AddrW-1:0]   ram_raddr_o,
  input  logic [DataW-1:0]   ram_rdata_i
);

  st_e               st_q, st_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CapW-1:0]   cap_q;
  req_t              req_q, req_d;
  logic              ok_q, ok_d;
  logic [DataW-1:0]  popv_q, popv_d;
  logic [DataW-1:0]  moved_q, moved_d;
  logic [AddrW-1:0]  rptr_q, rptr_d;
  logic [AddrW-1:0]  wptr_q, wptr_d;
  logic [DistW-1:0]  rem_q, rem_d;

  logic              push_ok, pop_ok, sink_ok;
  logic [AddrW-1:0]  top_addr;

  assign top_addr = AddrW'(count_q - 1'b1);
  assign push_ok  = (count_q != CntW'(Depth)) && (CmpW'(count_q) < CmpW'(cap_q));
  assign pop_ok   = (count_q != '0);
  assign sink_ok  = (req_q.sink_distance != '0) &&
                    (CmpW'(req_q.sink_distance) < CmpW'(count_q));

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: begin
        if (in_valid_i) st_d = StExec;
      end
      StExec: begin
        unique case (req_q.func)
          FnPush:   st_d = StResp;
          FnPop:    st_d = pop_ok ? StPopRd : StResp;
          FnSink:   st_d = sink_ok ? StSkFirst : StResp;
          FnStatus: st_d = StResp;
          default:  st_d = StResp;
        endcase
      end
      StPopRd:   st_d = StResp;
      StSkFirst: st_d = StSkShift;
      StSkShift: begin
        if (rem_q == DistW'(1)) st_d = StSkLast;
      end
      StSkLast:  st_d = StResp;
      StResp: begin
        if (rsp_ready_i) st_d = StIdle;
      end
      default:   st_d = StIdle;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready_o  = 1'b0;
    rsp_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = wptr_q;
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = rptr_q;
    count_d     = count_q;
    req_d       = req_q;
    ok_d        = ok_q;
    popv_d      = popv_q;
    moved_d     = moved_q;
    rptr_d      = rptr_q;
    wptr_d      = wptr_q;
    rem_d       = rem_q;
    unique case (st_q)
      StIdle: begin
        in_ready_o = 1'b1;
        req_d      = in_req_i;
      end
      StExec: begin
        ok_d   = 1'b0;
        popv_d = '0;
        unique case (req_q.func)
          FnPush: begin
            if (push_ok) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = AddrW'(count_q);
              ram_wdata_o = req_q.push_value;
              count_d     = CntW'(count_q + 1'b1);
              ok_d        = 1'b1;
            end
          end
          FnPop: begin
            if (pop_ok) begin
              ram_raddr_o = top_addr;
              count_d     = CntW'(count_q - 1'b1);
              ok_d        = 1'b1;
            end
          end
          FnSink: begin
            if (sink_ok) begin
              ram_raddr_o = top_addr;
              rptr_d      = top_addr - 1'b1;
              rem_d       = req_q.sink_distance;
              ok_d        = 1'b1;
            end
          end
          FnStatus: ok_d = 1'b1;
          default:  ok_d = 1'b1;
        endcase
      end
      StPopRd: popv_d = ram_rdata_i;
      StSkFirst: begin
        // old top word arrives; start reading the words beneath it
        moved_d     = ram_rdata_i;
        ram_raddr_o = rptr_q;
        rptr_d      = rptr_q - 1'b1;
        wptr_d      = rptr_q + 1'b1;
      end
      StSkShift: begin
        // each word read last cycle moves up one place
        ram_we_o    = 1'b1;
        ram_waddr_o = wptr_q;
        ram_wdata_o = ram_rdata_i;
        wptr_d      = wptr_q - 1'b1;
        rem_d       = rem_q - 1'b1;
        ram_raddr_o = rptr_q;
        rptr_d      = rptr_q - 1'b1;
      end
      StSkLast: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = wptr_q;
        ram_wdata_o = moved_q;
      end
      StResp: rsp_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      count_q <= '0;
      cap_q   <= CapReset;
    end else begin
      st_q    <= st_d;
      count_q <= count_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    ok_q    <= ok_d;
    popv_q  <= popv_d;
    moved_q <= moved_d;
    rptr_q  <= rptr_d;
    wptr_q  <= wptr_d;
    rem_q   <= rem_d;
  end

  assign rsp_o.ok        = ok_q;
  assign rsp_o.pop_value = popv_q;
  assign rsp_o.count     = CntOutW'(count_q);
  assign rsp_o.is_empty  = (count_q == '0);

endmodule

/* design/sws_outreg.sv */
// ----------------------------------------------------------------------------
// sws_outreg
// Result output register; frees the sequencer while a result waits.
// ----------------------------------------------------------------------------
module sws_outreg import sws_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic rsp_valid_i,
  output logic rsp_ready_o,
  input  rsp_t rsp_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  logic valid_q, valid_d;
  rsp_t data_q;
  logic load;

  assign rsp_ready_o = !valid_q || out_ready_i;
  assign load        = rsp_valid_i && rsp_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) data_q <= rsp_i;
  end

  assign out_valid_o = valid_q;
  assign out_rsp_o   = data_q;

endmodule

/* design/stack_with_sink_top.sv */
// ----------------------------------------------------------------------------
// stack_with_sink_top
// Bounded LIFO stack of 32-bit words with push, pop, sink and status requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_ready_o with in_req_i (func, push_value,
//   sink_distance). Every request yields exactly one result on
//   out_valid_o/out_ready_i with out_rsp_o (ok, pop_value, count, is_empty).
//   cfg_we_i/cfg_wdata_i write the capacity register (reset 64); write it
//   only while no request is in flight.
// Sequence:
//   One request is worked at a time by the sequencer. A push, a status and
//   any refused request go from execution straight to the result state; a
//   pop adds a read state for the registered RAM read; a sink of n places
//   adds a first read, a shift state and a last write state: the sink moves
//   one word per cycle through the single read port and single write port
//   of the stack RAM. The result then passes through the output register.
// Reset:
//   Stack empties, capacity returns to 64; RAM contents are not cleared.
// Stall:
//   A result held in the output register does not block the next request;
//   only when a second result is ready and the register is still full does
//   the sequencer wait, and in_ready_o stays low until it drains.
// ----------------------------------------------------------------------------
module stack_with_sink_top import sws_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  req_t            in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rsp_t            out_rsp_o,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i
);

  // stack RAM port
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [DataW-1:0]  ram_wdata;
  logic [AddrW-1:0]  ram_raddr;
  logic [DataW-1:0]  ram_rdata;

  // sequencer to output register
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // entry 0 is the bottom of the stack
  sws_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // output register decouples the receiver from the sequencer
  sws_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rsp_valid_i (rsp_valid),
    .rsp_ready_o (rsp_ready),
    .rsp_i       (rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

/* design/sws_chk.sv */
// ----------------------------------------------------------------------------
// sws_chk
// Port-level checks for the stack with sink block, bound to the top level.
// ----------------------------------------------------------------------------
module sws_chk import sws_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_rsp_o
);

  // count reported by the last delivered result
  logic [CntOutW-1:0] last_cnt_q;
  logic [CntOutW:0]   cur_w, last_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cnt_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      last_cnt_q <= out_rsp_o.count;
    end
  end

  assign cur_w  = {1'b0, out_rsp_o.count};
  assign last_w = {1'b0, last_cnt_q};

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // one request in flight: no acceptance right after another
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted in back-to-back cycles");

  // a refused request leaves the stack and returns no word
  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.ok |-> (out_rsp_o.count == last_cnt_q) &&
    (out_rsp_o.pop_value == '0))
    else $error("refused request changed count or returned a word");

  // count moves by at most one between results
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cur_w == last_w) || (cur_w == last_w + 1'b1) ||
    (cur_w + 1'b1 == last_w))
    else $error("count jumped between results");

endmodule

bind stack_with_sink_top sws_chk u_sws_chk (.*);
